// ----- rtl/utf8sv_pkg.sv -----
`timescale 1ns / 1ps
// Package for the UTF-8 stream validator: payload structs, byte constants
// and the second-byte range check. No dependencies.
package utf8sv_pkg;

    localparam int OUT_POS_BITS = 16;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } utf8sv_in_t;

    typedef struct packed {
        logic                    is_valid;
        logic [OUT_POS_BITS-1:0] error_position;
    } utf8sv_out_t;

    localparam logic [7:0] CONT_MASK   = 8'hc0;
    localparam logic [7:0] CONT_TAG    = 8'h80;
    localparam logic [7:0] LEAD2_MIN   = 8'hc2;
    localparam logic [7:0] LEAD2_MAX   = 8'hdf;
    localparam logic [7:0] LEAD3_MIN   = 8'he0;
    localparam logic [7:0] LEAD3_MAX   = 8'hef;
    localparam logic [7:0] LEAD4_MIN   = 8'hf0;
    localparam logic [7:0] LEAD4_MAX   = 8'hf3;
    localparam logic [7:0] LEAD_E0     = 8'he0;
    localparam logic [7:0] LEAD_ED     = 8'hed;
    localparam logic [7:0] LEAD_F0     = 8'hf0;
    localparam logic [7:0] LEAD_F4     = 8'hf4;
    localparam logic [7:0] E0_LOW      = 8'ha0;
    localparam logic [7:0] ED_HIGH     = 8'h9f;
    localparam logic [7:0] F0_LOW      = 8'h90;
    localparam logic [7:0] F4_HIGH     = 8'h8f;

    // Allowed range of the second byte for a given lead.
    // C0, C1 and F5..F7 always fail here.
    function automatic logic second_ok(input logic [7:0] lead, input logic [7:0] b);
        logic ok;
        ok = 1'b0;
        if (lead == LEAD_E0) begin
            ok = (b >= E0_LOW);
        end else if (lead == LEAD_ED) begin
            ok = (b <= ED_HIGH);
        end else if (lead == LEAD_F0) begin
            ok = (b >= F0_LOW);
        end else if (lead == LEAD_F4) begin
            ok = (b <= F4_HIGH);
        end else if (lead >= LEAD2_MIN && lead <= LEAD2_MAX) begin
            ok = 1'b1;
        end else if (lead >= LEAD3_MIN && lead <= LEAD3_MAX) begin
            ok = 1'b1;
        end else if (lead >= LEAD4_MIN && lead <= LEAD4_MAX) begin
            ok = 1'b1;
        end
        return ok;
    endfunction

endpackage

// ----- rtl/utf8_stream_validator_unit.sv -----
`timescale 1ns / 1ps
// Top level of the UTF-8 stream validator: core checker plus a two-entry
// output buffer. Depends on utf8sv_pkg and utf8sv_core.
//
//   channel | ports                      | carries
//   --------+----------------------------+----------------------------------
//   input   | s_valid, s_ready, s_data   | one string byte + last-byte flag
//   result  | m_valid, m_ready, m_data   | valid flag + first error position
//
// One byte is taken every cycle while s_ready is high; the decision for
// each byte is one level of logic into the state registers. The result of
// a string shows on m_data the cycle after its last byte is taken when the
// output register is free. Results sit in an output register backed by a
// skid register; s_ready drops only while both are full.
// aresetn (synchronous) clears the decode state and empties both entries.
module utf8_stream_validator_unit #(
    parameter int POSITION_BITS = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  utf8sv_pkg::utf8sv_in_t  s_data,
    output logic                    m_valid,
    input  logic                    m_ready,
    output utf8sv_pkg::utf8sv_out_t m_data
);
    import utf8sv_pkg::*;

    logic        in_fire;
    logic        res_fire;
    utf8sv_out_t res_item;

    logic        out_valid_reg, out_valid_next;
    utf8sv_out_t out_data_reg, out_data_next;
    logic        skid_valid_reg, skid_valid_next;
    utf8sv_out_t skid_data_reg, skid_data_next;

    assign s_ready = !skid_valid_reg;
    assign in_fire = s_valid && s_ready;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    utf8sv_core #(
        .POSITION_BITS(POSITION_BITS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_fire (in_fire),
        .in_item (s_data),
        .res_fire(res_fire),
        .res_item(res_item)
    );

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (out_valid_reg && m_ready) begin
            // head request taken: refill from skid, else from the core
            out_valid_next  = skid_valid_reg || res_fire;
            out_data_next   = skid_valid_reg ? skid_data_reg : res_item;
            skid_valid_next = 1'b0;
        end else if (!out_valid_reg) begin
            out_valid_next = res_fire;
            out_data_next  = res_item;
        end else if (res_fire) begin
            skid_valid_next = 1'b1;
            skid_data_next  = res_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

// ----- rtl/utf8sv_core.sv -----
`timescale 1ns / 1ps
// Per-byte UTF-8 decode state and checks; produces one result per string.
// Depends on utf8sv_pkg.
module utf8sv_core #(
    parameter int POSITION_BITS = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_fire,
    input  utf8sv_pkg::utf8sv_in_t  in_item,
    output logic                    res_fire,
    output utf8sv_pkg::utf8sv_out_t res_item
);
    import utf8sv_pkg::*;

    logic [POSITION_BITS-1:0] byte_index_reg, byte_index_next;
    logic [1:0]               bytes_left_reg, bytes_left_next;
    logic [7:0]               lead_value_reg, lead_value_next;
    logic [POSITION_BITS-1:0] lead_index_reg, lead_index_next;
    logic                     first_follow_reg, first_follow_next;
    logic                     error_seen_reg, error_seen_next;
    logic [POSITION_BITS-1:0] error_index_reg, error_index_next;

    logic [7:0]               b;
    logic [1:0]               cnt;
    logic                     bad;
    logic                     res_ok;
    logic [POSITION_BITS-1:0] err_pos;
    logic [31:0]              err_pos_ext;

    assign b = in_item.data_byte;

    always_comb begin
        byte_index_next   = byte_index_reg;
        bytes_left_next   = bytes_left_reg;
        lead_value_next   = lead_value_reg;
        lead_index_next   = lead_index_reg;
        first_follow_next = first_follow_reg;
        error_seen_next   = error_seen_reg;
        error_index_next  = error_index_reg;
        cnt               = 2'd0;
        bad               = 1'b0;
        err_pos           = '0;
        res_ok            = 1'b0;
        res_fire          = 1'b0;

        // lead class: 110xxxxx -> 1, 1110xxxx -> 2, 11110xxx -> 3, else none
        if (b[7:6] == 2'b11) begin
            if (!b[5]) begin
                cnt = 2'd1;
            end else if (!b[4]) begin
                cnt = 2'd2;
            end else if (!b[3]) begin
                cnt = 2'd3;
            end
        end

        if (in_fire) begin
            if (error_seen_reg) begin
                // only track whether the failing sequence completes
                if (bytes_left_reg != 2'd0) begin
                    bytes_left_next = bytes_left_reg - 2'd1;
                end
            end else if (bytes_left_reg == 2'd0) begin
                if (b[7]) begin
                    if (cnt == 2'd0) begin
                        error_seen_next  = 1'b1;
                        error_index_next = byte_index_reg;
                    end else begin
                        lead_value_next   = b;
                        lead_index_next   = byte_index_reg;
                        bytes_left_next   = cnt;
                        first_follow_next = 1'b1;
                    end
                end
            end else begin
                bad = ((b & CONT_MASK) != CONT_TAG)
                      || (first_follow_reg && !second_ok(lead_value_reg, b));
                if (bad) begin
                    error_seen_next  = 1'b1;
                    error_index_next = byte_index_reg;
                end
                first_follow_next = 1'b0;
                bytes_left_next   = bytes_left_reg - 2'd1;
            end

            if (!in_item.final_byte) begin
                if (byte_index_reg != '1) begin
                    byte_index_next = byte_index_reg + POSITION_BITS'(1);
                end
            end else begin
                // truncated sequence wins over anything inside it
                res_fire = 1'b1;
                if (bytes_left_next != 2'd0) begin
                    err_pos = lead_index_next;
                end else if (error_seen_next) begin
                    err_pos = error_index_next;
                end
                res_ok            = !(error_seen_next || (bytes_left_next != 2'd0));
                byte_index_next   = '0;
                bytes_left_next   = 2'd0;
                lead_value_next   = 8'd0;
                lead_index_next   = '0;
                first_follow_next = 1'b0;
                error_seen_next   = 1'b0;
                error_index_next  = '0;
            end
        end
    end

    assign err_pos_ext = 32'(err_pos);
    assign res_item    = '{is_valid: res_ok,
                           error_position: err_pos_ext[OUT_POS_BITS-1:0]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_index_reg   <= '0;
            bytes_left_reg   <= 2'd0;
            lead_value_reg   <= 8'd0;
            lead_index_reg   <= '0;
            first_follow_reg <= 1'b0;
            error_seen_reg   <= 1'b0;
            error_index_reg  <= '0;
        end else begin
            byte_index_reg   <= byte_index_next;
            bytes_left_reg   <= bytes_left_next;
            lead_value_reg   <= lead_value_next;
            lead_index_reg   <= lead_index_next;
            first_follow_reg <= first_follow_next;
            error_seen_reg   <= error_seen_next;
            error_index_reg  <= error_index_next;
        end
    end

endmodule
